FILE: hdl/stt_pkg.sv
`default_nettype none
package stt_pkg;

  localparam logic [62:0] VMAX = {63{1'b1}};
  localparam logic [23:0] LINE_MAX = {24{1'b1}};
  localparam logic [15:0] COL_MAX = {16{1'b1}};

  localparam logic [3:0] K_INTEGER = 4'd0;
  localparam logic [3:0] K_FLOAT = 4'd1;
  localparam logic [3:0] K_STRING = 4'd2;
  localparam logic [3:0] K_IDENT = 4'd3;
  localparam logic [3:0] K_COLON = 4'd4;
  localparam logic [3:0] K_AT = 4'd5;
  localparam logic [3:0] K_LBRACKET = 4'd6;
  localparam logic [3:0] K_RBRACKET = 4'd7;
  localparam logic [3:0] K_LBRACE = 4'd8;
  localparam logic [3:0] K_RBRACE = 4'd9;
  localparam logic [3:0] K_PIPE = 4'd10;
  localparam logic [3:0] K_NEWLINE = 4'd11;
  localparam logic [3:0] K_SYMBOL = 4'd12;
  localparam logic [3:0] K_STRCHAR = 4'd13;
  localparam logic [3:0] K_ERREND = 4'd14;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  // one result item
  typedef struct packed {
    logic [3:0]  kind;
    logic        eof;
    logic [7:0]  ch;
    logic [62:0] ip;
    logic [62:0] fp;
    logic [7:0]  fd;
    logic        ov;
    logic [23:0] ln;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_t;

  // up to three results of one request
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       r0;
    tok_t       r1;
    tok_t       r2;
  } bundle_t;

endpackage
`default_nettype wire

FILE: hdl/stt_front.sv
`default_nettype none
module stt_front import stt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic    in_end,
  output logic         q_push,
  output bundle_t      q_data,
  input  wire logic    q_full
);

  typedef enum logic [7:0] {
    M_IDLE = 8'b00000001, M_COMMENT = 8'b00000010, M_INT = 8'b00000100,
    M_DOT = 8'b00001000, M_FRAC = 8'b00010000, M_IDENT = 8'b00100000,
    M_STRING = 8'b01000000, M_ESCAPE = 8'b10000000
  } mode_t;

  mode_t mode, mode_next;
  logic [23:0] cur_line, cur_line_next, tok_line, tok_line_next;
  logic [15:0] cur_col, cur_col_next, tok_col, tok_col_next, tcount, tcount_next;
  logic [62:0] iacc, iacc_next, facc, facc_next;
  logic [7:0] fcount, fcount_next;
  logic ov, ov_next;

  // digit accumulate: mult by 10 then add, done combinationally on a 67-bit sum
  logic [66:0] acc10;
  logic [66:0] accsum;

  assign in_ready = !q_full;
  wire fire = in_valid && in_ready;

  function automatic logic isdig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic isalp(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction
  function automatic logic [3:0] punct(input logic [7:0] b);
    logic [3:0] k;
    k = K_SYMBOL;
    unique case (b)
      8'h3a: k = K_COLON;
      8'h40: k = K_AT;
      8'h5b: k = K_LBRACKET;
      8'h5d: k = K_RBRACKET;
      8'h7b: k = K_LBRACE;
      8'h7d: k = K_RBRACE;
      8'h7c: k = K_PIPE;
      8'h0a: k = K_NEWLINE;
      default: k = K_SYMBOL;
    endcase
    return k;
  endfunction

  tok_t res [3];
  logic [1:0] n;

  always_comb begin
    logic [62:0] acc_in;
    logic [7:0] b;
    logic [23:0] pl;
    logic [15:0] pc;
    logic dig;
    mode_t m;
    acc_in = '0;
    b = in_byte;
    pl = cur_line;
    pc = cur_col;
    dig = isdig(b);
    m = mode;
    mode_next = mode;
    cur_line_next = cur_line;
    cur_col_next = cur_col;
    tok_line_next = tok_line;
    tok_col_next = tok_col;
    tcount_next = tcount;
    iacc_next = iacc;
    facc_next = facc;
    fcount_next = fcount;
    ov_next = ov;
    n = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    acc_in = (mode == M_FRAC) ? facc : iacc;
    // times ten as eight plus two
    acc10 = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0};
    accsum = acc10 + {63'd0, b[3:0] - 4'd0};

    if (in_end) begin
      unique case (m)
        M_INT, M_FRAC: begin
          res[n] = '0; res[n].kind = (m == M_FRAC) ? K_FLOAT : K_INTEGER;
          res[n].ip = iacc; res[n].ov = ov;
          if (m == M_FRAC) begin res[n].fp = facc; res[n].fd = fcount; end
          res[n].ln = tok_line; res[n].col = tok_col; res[n].len = tcount;
          n = n + 2'd1;
        end
        M_DOT: begin
          res[n].kind = K_INTEGER; res[n].ip = iacc; res[n].ov = ov;
          res[n].ln = tok_line; res[n].col = tok_col; res[n].len = tcount;
          n = n + 2'd1;
          res[n].kind = K_SYMBOL; res[n].ch = 8'h2e; res[n].ln = pl;
          res[n].col = pc; res[n].len = 16'd1;
          n = n + 2'd1;
          if (pc != COL_MAX) pc = pc + 16'd1;
        end
        M_IDENT: begin
          res[n].kind = K_IDENT; res[n].ln = tok_line; res[n].col = tok_col;
          res[n].len = tcount; n = n + 2'd1;
        end
        M_ESCAPE: begin
          res[n].kind = K_STRCHAR; res[n].ch = 8'h5c; res[n].ln = tok_line;
          res[n].col = tok_col; res[n].len = tcount; n = n + 2'd1;
          res[n].kind = K_ERREND; res[n].ln = tok_line; res[n].col = tok_col;
          res[n].len = tcount; n = n + 2'd1;
        end
        M_STRING: begin
          res[n].kind = K_ERREND; res[n].ln = tok_line; res[n].col = tok_col;
          res[n].len = tcount; n = n + 2'd1;
        end
        default: ;
      endcase
      res[n] = '0; res[n].kind = K_ERREND; res[n].eof = 1'b1;
      res[n].ln = pl; res[n].col = pc;
      n = n + 2'd1;
      mode_next = M_IDLE; cur_line_next = 24'd1; cur_col_next = 16'd1;
      tok_line_next = 24'd1; tok_col_next = 16'd1; tcount_next = '0;
      iacc_next = '0; facc_next = '0; fcount_next = '0; ov_next = 1'b0;
    end else begin
      logic do_idle;
      logic idle_dot;
      do_idle = 1'b0;
      idle_dot = 1'b0;
      unique case (m)
        M_COMMENT: if (b == 8'h0a) do_idle = 1'b1;
        M_INT: begin
          if (dig) begin
            if (accsum > {4'd0, VMAX}) begin iacc_next = VMAX; ov_next = 1'b1; end
            else iacc_next = accsum[62:0];
            tcount_next = (tcount == COL_MAX) ? COL_MAX : tcount + 16'd1;
          end else if (b == 8'h2e) mode_next = M_DOT;
          else begin
            res[n].kind = K_INTEGER; res[n].ip = iacc; res[n].ov = ov;
            res[n].ln = tok_line; res[n].col = tok_col; res[n].len = tcount;
            n = n + 2'd1; do_idle = 1'b1;
          end
        end
        M_DOT: begin
          if (dig) begin
            facc_next = {59'd0, b[3:0]}; fcount_next = 8'd1;
            tcount_next = (tcount >= 16'hfffe) ? COL_MAX : tcount + 16'd2;
            if (pc != COL_MAX) pc = pc + 16'd1;
            mode_next = M_FRAC;
          end else begin
            res[n].kind = K_INTEGER; res[n].ip = iacc; res[n].ov = ov;
            res[n].ln = tok_line; res[n].col = tok_col; res[n].len = tcount;
            n = n + 2'd1;
            res[n].kind = K_SYMBOL; res[n].ch = 8'h2e; res[n].ln = pl;
            res[n].col = pc; res[n].len = 16'd1; n = n + 2'd1;
            if (pc != COL_MAX) pc = pc + 16'd1;
            idle_dot = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (dig) begin
            if (accsum > {4'd0, VMAX}) begin facc_next = VMAX; ov_next = 1'b1; end
            else facc_next = accsum[62:0];
            if (fcount != 8'hff) fcount_next = fcount + 8'd1;
            else ov_next = 1'b1;
            tcount_next = (tcount == COL_MAX) ? COL_MAX : tcount + 16'd1;
          end else begin
            res[n].kind = K_FLOAT; res[n].ip = iacc; res[n].fp = facc;
            res[n].fd = fcount; res[n].ov = ov;
            res[n].ln = tok_line; res[n].col = tok_col; res[n].len = tcount;
            n = n + 2'd1; do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (isalp(b) || dig || b == 8'h5f)
            tcount_next = (tcount == COL_MAX) ? COL_MAX : tcount + 16'd1;
          else begin
            res[n].kind = K_IDENT; res[n].ln = tok_line; res[n].col = tok_col;
            res[n].len = tcount; n = n + 2'd1; do_idle = 1'b1;
          end
        end
        M_STRING, M_ESCAPE: begin
          logic [15:0] tc;
          tc = (tcount == COL_MAX) ? COL_MAX : tcount + 16'd1;
          tcount_next = tc;
          if (m == M_ESCAPE) begin
            res[n].kind = K_STRCHAR;
            res[n].ch = (b == 8'h6e) ? 8'd10 : ((b == 8'h74) ? 8'd9 : b);
            res[n].ln = tok_line; res[n].col = tok_col; res[n].len = tc;
            n = n + 2'd1; mode_next = M_STRING;
          end else if (b == 8'h22) begin
            res[n].kind = K_STRING; res[n].ln = tok_line; res[n].col = tok_col;
            res[n].len = tc; n = n + 2'd1; mode_next = M_IDLE;
          end else if (b == 8'h5c) mode_next = M_ESCAPE;
          else begin
            res[n].kind = K_STRCHAR; res[n].ch = b; res[n].ln = tok_line;
            res[n].col = tok_col; res[n].len = tc; n = n + 2'd1;
          end
        end
        default: do_idle = 1'b1;
      endcase
      // common idle handling for the current byte
      if (do_idle) begin
        mode_next = M_IDLE;
        if (b == 8'h20 || b == 8'h09 || b == 8'h0d) begin
        end else if (b == 8'h23) mode_next = M_COMMENT;
        else if (dig) begin
          tok_line_next = pl; tok_col_next = pc; tcount_next = 16'd1;
          iacc_next = {59'd0, b[3:0]}; facc_next = '0; fcount_next = '0;
          ov_next = 1'b0; mode_next = M_INT;
        end else if (b == 8'h22 || isalp(b) || b == 8'h5f) begin
          tok_line_next = pl; tok_col_next = pc; tcount_next = 16'd1;
          iacc_next = '0; facc_next = '0; fcount_next = '0; ov_next = 1'b0;
          mode_next = (b == 8'h22) ? M_STRING : M_IDENT;
        end else begin
          res[n].kind = punct(b);
          if (punct(b) == K_SYMBOL) res[n].ch = b;
          res[n].ln = pl; res[n].col = pc; res[n].len = 16'd1;
          n = n + 2'd1;
        end
      end
      // advance position past the current byte
      if (!(m == M_INT && !dig && b == 8'h2e)) begin
        if (b == 8'h0a) begin
          if (pl != LINE_MAX) pl = pl + 24'd1;
          pc = 16'd1;
        end else if (pc != COL_MAX) pc = pc + 16'd1;
      end
      if (idle_dot) ; // dot column already stepped above
      cur_line_next = pl;
      cur_col_next = pc;
    end
    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  assign q_push = fire && (n != 2'd0);
  always_comb begin
    q_data.cnt = n;
    q_data.r0 = res[0];
    q_data.r1 = res[1];
    q_data.r2 = res[2];
  end

  // hold scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; cur_line <= 24'd1; cur_col <= 16'd1;
      tok_line <= 24'd1; tok_col <= 16'd1; tcount <= '0;
      iacc <= '0; facc <= '0; fcount <= '0; ov <= 1'b0;
    end else if (fire) begin
      mode <= mode_next; cur_line <= cur_line_next; cur_col <= cur_col_next;
      tok_line <= tok_line_next; tok_col <= tok_col_next; tcount <= tcount_next;
      iacc <= iacc_next; facc <= facc_next; fcount <= fcount_next; ov <= ov_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/stt_back.sv
`default_nettype none
module stt_back import stt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_push,
  input  bundle_t   q_data,
  output logic      q_full,
  output logic      out_valid,
  input  wire logic out_ready,
  output tok_t      out_tok
);

  bundle_t mem [QDEPTH];
  logic [QAW:0] wp, rp;
  logic [1:0] sub;

  wire [QAW:0] used = wp - rp;
  assign q_full = (used == QDEPTH[QAW:0]);
  wire empty = (wp == rp);
  bundle_t head;
  assign head = mem[rp[QAW-1:0]];

  assign out_valid = !empty;
  always_comb begin
    unique case (sub)
      2'd0: out_tok = head.r0;
      2'd1: out_tok = head.r1;
      default: out_tok = head.r2;
    endcase
  end

  wire take = out_valid && out_ready;
  wire done = take && (sub == head.cnt - 2'd1);

  // store requests from the front
  always_ff @(posedge clk) begin
    if (q_push) mem[wp[QAW-1:0]] <= q_data;
  end

  // advance queue pointers and sub-item index
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; sub <= '0;
    end else begin
      if (q_push) wp <= wp + 1'b1;
      if (done) begin
        rp <= rp + 1'b1; sub <= '0;
      end else if (take) sub <= sub + 2'd1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/source_text_tokenizer_unit.sv
// channel | request       | tdata (low bit up)              | tuser / tlast
// s_axis  | source byte   | source_byte[7:0]                | tuser: end_marker
// m_axis  | result token  | char_value, integer_part,       | tuser: kind,
//         |               | fraction_part, fraction_digits, | is_end_of_file
//         |               | value_overflow, start_line,     | tlast: last_of_run
//         |               | start_column, token_length      |
// One byte is taken per cycle while the queue is not full; a byte with k results yields k output tokens.
// The front scanner handles a byte in the cycle it is accepted; a four-entry
// queue of result groups decouples it from output stalls.
// The input waits while the queue holds four groups.
// Reset is synchronous and clears scanner state and the queue.
`default_nettype none
module source_text_tokenizer_unit import stt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // source_byte
  input  wire logic         s_axis_tuser,  // end_marker
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // char_value[7:0], integer_part[70:8], fraction_part[133:71],
  // fraction_digits[141:134], value_overflow[142], start_line[166:143],
  // start_column[182:167], token_length[198:183], zero fill to 200
  output logic [199:0]      m_axis_tdata,
  output logic [4:0]        m_axis_tuser,  // kind[3:0], is_end_of_file[4]
  output logic              m_axis_tlast
);

  logic q_push, q_full;
  bundle_t q_data;
  tok_t t;

  stt_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_end(s_axis_tuser),
    .q_push(q_push), .q_data(q_data), .q_full(q_full)
  );

  stt_back u_back (
    .clk(clk), .rst(rst), .q_push(q_push), .q_data(q_data), .q_full(q_full),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_tok(t)
  );

  assign m_axis_tdata = {1'b0, t.len, t.col, t.ln, t.ov, t.fd, t.fp, t.ip, t.ch};
  assign m_axis_tuser = {t.eof, t.kind};
  assign m_axis_tlast = t.last;

endmodule
`default_nettype wire

FILE: bench/source_text_tokenizer_unit_tb.sv
`default_nettype none
module source_text_tokenizer_unit_tb;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 110;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_LBRK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRK = 8'h5d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_LBRC = 8'h7b;
  localparam logic [7:0] CH_PIPE = 8'h7c;
  localparam logic [7:0] CH_RBRC = 8'h7d;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_IDENT, SCAN_STRING,
    SCAN_ESCAPE
  } scan_e;

  // Lexer predictor and queue of expected tokens
  class lexer_scoreboard;
    scan_e mode;
    logic [23:0] line, tok_line;
    logic [15:0] column, tok_col, tok_len;
    logic [62:0] int_acc, frac_acc;
    logic [7:0] frac_cnt;
    logic ovf;
    tok_t token_q[$];
    tok_t step_q[$];
    int errors;
    int mismatches;

    function new();
      clear();
      errors = 0;
      mismatches = 0;
    endfunction

    function void clear();
      mode = SCAN_IDLE;
      line = 1;
      column = 1;
      tok_line = 1;
      tok_col = 1;
      tok_len = 0;
      int_acc = 0;
      frac_acc = 0;
      frac_cnt = 0;
      ovf = 0;
    endfunction

    function void push(logic [3:0] kind, logic eof, logic [7:0] ch, logic [62:0] ip,
                       logic [62:0] fp, logic [7:0] fd, logic ov, logic [23:0] ln,
                       logic [15:0] col, logic [15:0] len);
      tok_t t;
      t.kind = kind; t.eof = eof; t.ch = ch; t.ip = ip; t.fp = fp; t.fd = fd;
      t.ov = ov; t.ln = ln; t.col = col; t.len = len; t.last = 1'b0;
      if (step_q.size() < 3) step_q.insert(step_q.size(), t);
    endfunction

    function void push_tok(logic [3:0] kind, logic [7:0] ch);
      push(kind, 0, ch, 0, 0, 0, 0, tok_line, tok_col, tok_len);
    endfunction

    function void push_num(bit is_float);
      push(is_float ? K_FLOAT : K_INTEGER, 0, 0, int_acc, is_float ? frac_acc : 63'd0,
           is_float ? frac_cnt : 8'd0, ovf, tok_line, tok_col, tok_len);
    endfunction

    // Advance the source position past one byte
    function void move(logic [7:0] b);
      if (b == CH_LF) begin
        if (line != LINE_MAX) line++;
        column = 1;
      end else if (column != COL_MAX) begin
        column++;
      end
    endfunction

    function void grow(int k);
      int s;
      s = int'(tok_len) + k;
      tok_len = (s > 65535) ? 16'hffff : s[15:0];
    endfunction

    function logic [62:0] add_digit(logic [62:0] acc, logic [7:0] b);
      logic [62:0] d;
      d = 63'(b - CH_ZERO);
      if (acc > (VMAX - d) / 10) begin
        ovf = 1;
        return VMAX;
      end
      return acc * 10 + d;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function void begin_tok();
      tok_line = line;
      tok_col = column;
      tok_len = 1;
      int_acc = 0;
      frac_acc = 0;
      frac_cnt = 0;
      ovf = 0;
    endfunction

    function void idle_char(logic [7:0] b);
      logic [3:0] kind;
      bit punct;
      punct = 1;
      if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
        move(b);
        return;
      end
      if (b == CH_HASH) begin
        mode = SCAN_COMMENT;
        move(b);
        return;
      end
      if (is_digit(b)) begin
        begin_tok();
        int_acc = 63'(b - CH_ZERO);
        mode = SCAN_INT;
        move(b);
        return;
      end
      if (b == CH_QUOTE) begin
        begin_tok();
        mode = SCAN_STRING;
        move(b);
        return;
      end
      if (is_alpha(b) || b == CH_UNDER) begin
        begin_tok();
        mode = SCAN_IDENT;
        move(b);
        return;
      end
      case (b)
        CH_COLON: kind = K_COLON;
        CH_AT:    kind = K_AT;
        CH_LBRK:  kind = K_LBRACKET;
        CH_RBRK:  kind = K_RBRACKET;
        CH_LBRC:  kind = K_LBRACE;
        CH_RBRC:  kind = K_RBRACE;
        CH_PIPE:  kind = K_PIPE;
        CH_LF:    kind = K_NEWLINE;
        default: begin
          kind = K_SYMBOL;
          punct = 0;
        end
      endcase
      push(kind, 0, punct ? 8'd0 : b, 0, 0, 0, 0, line, column, 1);
      move(b);
    endfunction

    // Work out the tokens caused by one accepted request
    function void note_request(logic [7:0] b, logic end_mark);
      step_q.delete();
      if (end_mark) begin
        case (mode)
          SCAN_INT: push_num(0);
          SCAN_DOT: begin
            push_num(0);
            push(K_SYMBOL, 0, CH_DOT, 0, 0, 0, 0, line, column, 1);
            move(CH_DOT);
          end
          SCAN_FRAC: push_num(1);
          SCAN_IDENT: push_tok(K_IDENT, 0);
          SCAN_ESCAPE: begin
            push_tok(K_STRCHAR, CH_BSLASH);
            push_tok(K_ERREND, 0);
          end
          SCAN_STRING: push_tok(K_ERREND, 0);
          default: ;
        endcase
        push(K_ERREND, 1, 0, 0, 0, 0, 0, line, column, 0);
        clear();
      end else begin
        case (mode)
          SCAN_COMMENT:
            if (b == CH_LF) begin
              mode = SCAN_IDLE;
              idle_char(b);
            end else move(b);
          SCAN_INT:
            if (is_digit(b)) begin
              int_acc = add_digit(int_acc, b);
              grow(1);
              move(b);
            end else if (b == CH_DOT) mode = SCAN_DOT;
            else begin
              push_num(0);
              mode = SCAN_IDLE;
              idle_char(b);
            end
          SCAN_DOT:
            if (is_digit(b)) begin
              frac_acc = 63'(b - CH_ZERO);
              frac_cnt = 1;
              grow(2);
              move(CH_DOT);
              move(b);
              mode = SCAN_FRAC;
            end else begin
              push_num(0);
              mode = SCAN_IDLE;
              idle_char(CH_DOT);
              idle_char(b);
            end
          SCAN_FRAC:
            if (is_digit(b)) begin
              frac_acc = add_digit(frac_acc, b);
              if (frac_cnt != 8'hff) frac_cnt++;
              else ovf = 1;
              grow(1);
              move(b);
            end else begin
              push_num(1);
              mode = SCAN_IDLE;
              idle_char(b);
            end
          SCAN_IDENT:
            if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
              grow(1);
              move(b);
            end else begin
              push_tok(K_IDENT, 0);
              mode = SCAN_IDLE;
              idle_char(b);
            end
          SCAN_STRING: begin
            grow(1);
            if (b == CH_QUOTE) begin
              push_tok(K_STRING, 0);
              mode = SCAN_IDLE;
            end else if (b == CH_BSLASH) mode = SCAN_ESCAPE;
            else push_tok(K_STRCHAR, b);
            move(b);
          end
          SCAN_ESCAPE: begin
            grow(1);
            push_tok(K_STRCHAR, b == CH_N ? CH_LF : (b == CH_T ? CH_TAB : b));
            move(b);
            mode = SCAN_STRING;
          end
          default: idle_char(b);
        endcase
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) token_q.insert(token_q.size(), step_q[i]);
    endfunction

    // Compare one output token with the oldest expectation
    function void check_result(tok_t got);
      tok_t want;
      if (token_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d ch %h ln %0d col %0d len %0d",
                   got.kind, got.ch, got.ln, got.col, got.len);
        return;
      end
      want = token_q.pop_front();
      if (got !== want) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("token mismatch, expected: kind %0d eof %b ch %h ip %0d fp %0d fd %0d ov %b ln %0d col %0d len %0d last %b",
                   want.kind, want.eof, want.ch, want.ip, want.fp, want.fd, want.ov,
                   want.ln, want.col, want.len, want.last);
          $display("token mismatch, actual:   kind %0d eof %b ch %h ip %0d fp %0d fd %0d ov %b ln %0d col %0d len %0d last %b",
                   got.kind, got.eof, got.ch, got.ip, got.fp, got.fd, got.ov,
                   got.ln, got.col, got.len, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  logic [4:0] m_axis_tuser;
  logic m_axis_tlast;

  lexer_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int cycles = 0;
  int sent = 0;
  logic [7:0] text_q[$];

  source_text_tokenizer_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** source_text_tokenizer_unit: FAILED **");
      $finish;
    end
  end

  // Stall the output side at random
  always @(negedge clk)
    m_axis_tready <= !rst && (!gaps_on || $urandom_range(99) >= 28);

  // Check every accepted token
  always @(posedge clk) begin
    tok_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser[3:0];
      got.eof = m_axis_tuser[4];
      got.ch = m_axis_tdata[7:0];
      got.ip = m_axis_tdata[70:8];
      got.fp = m_axis_tdata[133:71];
      got.fd = m_axis_tdata[141:134];
      got.ov = m_axis_tdata[142];
      got.ln = m_axis_tdata[166:143];
      got.col = m_axis_tdata[182:167];
      got.len = m_axis_tdata[198:183];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // Offer one request, called at a falling edge, returns at a falling edge
  task send_request(input logic [7:0] b, input logic end_mark);
    while (gaps_on && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= end_mark;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(b, end_mark);
    sent++;
    @(negedge clk);
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task send_queued();
    while (text_q.size() > 0) send_request(text_q.pop_front(), 1'b0);
  endtask

  // Append one byte to the pending text
  function void queue_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Hold the sender until every expected token is out
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.token_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function logic [7:0] pick_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    return CH_UNDER;
  endfunction

  // Build one token with random content; some are left malformed
  task make_token();
    int n;
    case ($urandom_range(11))
      0, 1: begin
        n = ($urandom_range(9) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 4);
        repeat (n) queue_byte(pick_digit());
        if ($urandom_range(2) == 0) begin
          queue_byte(CH_DOT);
          n = ($urandom_range(9) == 0) ? $urandom_range(18, 22) : $urandom_range(0, 3);
          repeat (n) queue_byte(pick_digit());
        end
      end
      2, 3: begin
        queue_byte(pick_letter());
        repeat ($urandom_range(5))
          queue_byte($urandom_range(1) ? pick_letter() : pick_digit());
      end
      4, 5: begin
        queue_byte(CH_QUOTE);
        repeat ($urandom_range(5)) begin
          case ($urandom_range(5))
            0: begin
              queue_byte(CH_BSLASH);
              case ($urandom_range(3))
                0: queue_byte(CH_N);
                1: queue_byte(CH_T);
                2: queue_byte(CH_QUOTE);
                default: queue_byte(8'($urandom_range(255)));
              endcase
            end
            1: queue_byte(CH_LF);
            default: queue_byte(8'($urandom_range(32, 126)) == CH_QUOTE ? 8'h41 :
                                8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(7) != 0) queue_byte(CH_QUOTE);
      end
      6: begin
        queue_byte(CH_HASH);
        repeat ($urandom_range(4)) queue_byte(8'($urandom_range(255)) | 8'h80);
        queue_byte(CH_LF);
      end
      7: begin
        case ($urandom_range(7))
          0: queue_byte(CH_COLON);
          1: queue_byte(CH_AT);
          2: queue_byte(CH_LBRK);
          3: queue_byte(CH_RBRK);
          4: queue_byte(CH_LBRC);
          5: queue_byte(CH_RBRC);
          6: queue_byte(CH_PIPE);
          default: queue_byte(CH_LF);
        endcase
      end
      8: queue_byte(8'($urandom_range(255)));
      default: begin
        case ($urandom_range(3))
          0: queue_byte(CH_TAB);
          1: queue_byte(CH_CR);
          2: queue_byte(CH_LF);
          default: queue_byte(CH_SPACE);
        endcase
      end
    endcase
  endtask

  initial begin
    int mark;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: punctuation, numbers, held dot, escapes, comments, odd bytes
    send_text("9.5:@[]{}|\n");
    send_text("7.x_a9 ");
    send_request(CH_QUOTE, 1'b0);
    send_text("a\\n\\t\\q\n");
    send_request(CH_QUOTE, 1'b0);
    send_text("#c\r\t\n");
    send_request(8'hff, 1'b0);
    send_request(8'h00, 1'b0);
    send_text("3.");
    send_request(8'hff, 1'b1);
    send_request(CH_QUOTE, 1'b0);
    send_request(CH_BSLASH, 1'b0);
    send_request(8'h00, 1'b1);
    send_text("\"x");
    send_request(8'h00, 1'b1);
    send_request(8'h5a, 1'b1);
    drain();

    // Saturation: integer and fraction values
    send_text("\n0.");
    send_text(" 99999999999999999999 1.99999999999999999999");
    send_request(8'h00, 1'b1);
    drain();

    // Random token streams, with a stretch of no stalls in the middle
    mark = sent;
    while (sent - mark < RANDOM_ITEMS) begin
      gaps_on = !((sent - mark) > 30 && (sent - mark) < 80);
      if ($urandom_range(24) == 0) send_request(8'($urandom_range(255)), 1'b1);
      else begin
        make_token();
        if ($urandom_range(2) == 0) queue_byte(CH_SPACE);
        send_queued();
      end
    end
    gaps_on = 1'b1;
    send_request(8'h00, 1'b1);
    s_axis_tvalid <= 1'b0;

    while (sb.token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.token_q.size() == 0)
      $display("** source_text_tokenizer_unit: PASSED **");
    else
      $display("** source_text_tokenizer_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
